FILE: rtl/lpd_pkg.sv
package lpd_pkg;

   localparam int LENGTH_BYTES = 4;
   localparam int LEN_W        = 32;
   localparam int BYTE_W       = 8;
   localparam int HDR_CNT_W    = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

   typedef enum logic [1:0] {
      PH_KIND_HDR  = 2'd0,
      PH_KIND_DATA = 2'd1,
      PH_PAY_HDR   = 2'd2,
      PH_PAY_DATA  = 2'd3
   } phase_type;

endpackage

FILE: rtl/length_prefixed_deframer.sv
// Channel   Dir  Ports                      Contents (lowest bit up)
// req       in   req_tvalid/tready/tdata    tdata: in_byte[7:0]
// rsp       out  rsp_tvalid/tready/tdata    tdata: out_byte[7:0]
//                rsp_tuser, rsp_tlast       tuser: field_is_payload, has_data,
//                                           last_of_field; tlast: last_of_frame
//
// One byte per cycle while req_tready is high; each result is registered and
// appears the cycle after its byte is taken; the result register is the only stage.
// Synchronous active-high reset returns to the kind length header, output empty.
// req_tready drops only while a result is held and rsp_tready is low.
module length_prefixed_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [2:0] rsp_tuser,   // field_is_payload, has_data, last_of_field
   output logic       rsp_tlast    // last_of_frame
);

   lpd_pkg::phase_type                  phase_ff, phase_in;
   logic [lpd_pkg::HDR_CNT_W-1:0]       hdr_cnt_ff, hdr_cnt_in;
   logic [lpd_pkg::LEN_W-1:0]           len_ff, len_in;
   logic [lpd_pkg::LEN_W-1:0]           rem_ff, rem_in;
   logic                                valid_ff, valid_in;
   logic [lpd_pkg::BYTE_W-1:0]          byte_ff, byte_in;
   logic [2:0]                          user_ff, user_in;
   logic                                last_ff, last_in;

   logic                                take;
   logic                                is_pay;
   logic                                is_hdr;
   logic [lpd_pkg::LEN_W-1:0]           shifted;
   logic [lpd_pkg::LEN_W-1:0]           rem_dec;
   logic                                hdr_done;

   assign req_tready = !valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   assign is_pay   = (phase_ff == lpd_pkg::PH_PAY_HDR) || (phase_ff == lpd_pkg::PH_PAY_DATA);
   assign is_hdr   = (phase_ff == lpd_pkg::PH_KIND_HDR) || (phase_ff == lpd_pkg::PH_PAY_HDR);
   assign shifted  = {len_ff[lpd_pkg::LEN_W-lpd_pkg::BYTE_W-1:0], req_tdata};
   assign hdr_done = (hdr_cnt_ff == lpd_pkg::HDR_CNT_W'(lpd_pkg::LENGTH_BYTES - 1));
   assign rem_dec  = (rem_ff != '0) ? rem_ff - lpd_pkg::LEN_W'(1) : rem_ff;

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      len_in     = len_ff;
      rem_in     = rem_ff;
      valid_in   = valid_ff && !rsp_tready;
      byte_in    = byte_ff;
      user_in    = user_ff;
      last_in    = last_ff;
      if (take) begin
         if (is_hdr) begin
            len_in = shifted;
            if (!hdr_done) begin
               hdr_cnt_in = hdr_cnt_ff + lpd_pkg::HDR_CNT_W'(1);
            end else begin
               hdr_cnt_in = '0;
               if (shifted == '0) begin
                  valid_in = 1'b1;
                  byte_in  = '0;
                  user_in  = {1'b1, 1'b0, is_pay};
                  last_in  = is_pay;
                  phase_in = is_pay ? lpd_pkg::PH_KIND_HDR : lpd_pkg::PH_PAY_HDR;
               end else begin
                  rem_in   = shifted;
                  len_in   = '0;
                  phase_in = is_pay ? lpd_pkg::PH_PAY_DATA : lpd_pkg::PH_KIND_DATA;
               end
            end
         end else begin
            rem_in   = rem_dec;
            valid_in = 1'b1;
            byte_in  = req_tdata;
            if (rem_dec == '0) begin
               user_in    = {1'b1, 1'b1, is_pay};
               last_in    = is_pay;
               phase_in   = is_pay ? lpd_pkg::PH_KIND_HDR : lpd_pkg::PH_PAY_HDR;
               len_in     = '0;
               hdr_cnt_in = '0;
            end else begin
               user_in = {1'b0, 1'b1, is_pay};
               last_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lpd_pkg::PH_KIND_HDR;
         hdr_cnt_ff <= '0;
         len_ff     <= '0;
         rem_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         len_ff     <= len_in;
         rem_ff     <= rem_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: rtl/lpd_checker.sv
module lpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);

   // held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transfer changed while stalled");

   // empty marker: zero byte, closes its field
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata == 8'd0 && rsp_tuser[2])
      else $error("empty marker malformed");

   // frame ends only on the end of a payload field
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0] && rsp_tuser[2])
      else $error("frame end outside payload field end");

   // input never blocked while the output slot is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("req stalled with free output");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (.*);
